### design/tcp_conntrack_fsm_table_core_macros.svh
// ----------------------------------------------------------------------------
// TCP connection tracking core: assertion macros
// Shared concurrent assertion forms. Each samples on clk_i and is disabled
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TCP_CONNTRACK_FSM_TABLE_CORE_MACROS_SVH
`define TCP_CONNTRACK_FSM_TABLE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/tcf_pkg.sv
// ----------------------------------------------------------------------------
// TCP connection tracking package
// Widths, codes, the flag decode and the fixed connection transition table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcf_pkg;

  // Table size and derived widths.
  localparam int FLOW_ENTRIES = 4096;
  localparam int FlowAw       = $clog2(FLOW_ENTRIES);
  localparam int IdxW         = 12;
  localparam int RangeW       = ((IdxW > FlowAw) ? IdxW : FlowAw) + 1;

  // Field widths.
  localparam int TickW     = 48;
  localparam int FlagW     = 8;
  localparam int StW       = 4;
  localparam int MkW       = 2;
  localparam int EntryW    = StW + MkW;
  localparam int StatusW   = 2;
  localparam int NumTimers = 8;
  localparam int TmIdxW    = $clog2(NumTimers);
  localparam int CfgIdxW   = 3;

  // Fixed timeout of the closing-ACK state.
  localparam logic [TickW-1:0] CLOSING_ACK_TICKS = 48'd30000000000;

  // Command queue between front and back.
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Flag bit positions.
  localparam int FlagFin = 0;
  localparam int FlagSyn = 1;
  localparam int FlagRst = 2;
  localparam int FlagAck = 4;

  typedef enum logic [StW-1:0] {
    ST_NONE        = 4'd0,
    ST_SYN_SENT    = 4'd1,
    ST_SYN_RECV    = 4'd2,
    ST_ESTABLISHED = 4'd3,
    ST_FIN_WAIT    = 4'd4,
    ST_CLOSE_WAIT  = 4'd5,
    ST_CLOSING_ACK = 4'd6,
    ST_TIME_WAIT   = 4'd7,
    ST_CLOSE       = 4'd8,
    ST_MID_STREAM  = 4'd9
  } conn_state_e;

  typedef enum logic [2:0] {
    EV_SYN     = 3'd0,
    EV_SYNACK  = 3'd1,
    EV_ACK     = 3'd2,
    EV_FIN_IN  = 3'd3,
    EV_FIN_OUT = 3'd4,
    EV_RST     = 3'd5,
    EV_NONE    = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    MK_KEEP = 2'd0,
    MK_IN   = 2'd1,
    MK_OUT  = 2'd2,
    MK_CLR  = 2'd3
  } mark_op_e;

  typedef enum logic [3:0] {
    TM_SYN_SENT    = 4'd0,
    TM_SYN_RECV    = 4'd1,
    TM_ESTABLISHED = 4'd2,
    TM_FIN_WAIT    = 4'd3,
    TM_CLOSE_WAIT  = 4'd4,
    TM_TIME_WAIT   = 4'd5,
    TM_CLOSE       = 4'd6,
    TM_MID_STREAM  = 4'd7,
    TM_CLOSING_ACK = 4'd8
  } timer_sel_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_APPLIED = 2'd0,
    STATUS_IGNORED = 2'd1,
    STATUS_CORRUPT = 2'd2
  } status_e;

  // One row of the transition table.
  typedef struct packed {
    logic        valid;
    conn_state_e next;
    mark_op_e    mark;
    timer_sel_e  timer;
    logic        refresh;
    logic        mid_ack;
  } rule_t;

  // Classified packet event as it travels from front to back.
  typedef struct packed {
    logic [IdxW-1:0]  flow_index;
    logic             from_outside;
    logic [TickW-1:0] now_ticks;
    event_e           event_code;
    logic             in_range;
  } cmd_t;

  // Queue status seen by front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // One result item.
  typedef struct packed {
    status_e            status;
    logic [IdxW-1:0]    flow_echo;
    logic [StW-1:0]     new_state;
    logic [MkW-1:0]     close_marks;
    logic               arm_expiry;
    logic               refresh_only;
    logic [TickW-1:0]   deadline_ticks;
  } result_t;

  // Flag byte to event, by priority RST, SYN, FIN, ACK.
  function automatic event_e decode_event(input logic [FlagW-1:0] flags,
                                          input logic outside);
    event_e ev;
    if (flags[FlagRst]) begin
      ev = EV_RST;
    end else if (flags[FlagSyn]) begin
      ev = flags[FlagAck] ? EV_SYNACK : EV_SYN;
    end else if (flags[FlagFin]) begin
      ev = outside ? EV_FIN_OUT : EV_FIN_IN;
    end else if (flags[FlagAck]) begin
      ev = EV_ACK;
    end else begin
      ev = EV_NONE;
    end
    return ev;
  endfunction

  function automatic rule_t mk_rule(input conn_state_e nxt, input mark_op_e mk,
                                    input timer_sel_e tm, input logic refresh,
                                    input logic mid_ack);
    rule_t r;
    r.valid   = 1'b1;
    r.next    = nxt;
    r.mark    = mk;
    r.timer   = tm;
    r.refresh = refresh;
    r.mid_ack = mid_ack;
    return r;
  endfunction

  // Transition table. Pairs without a row return an invalid rule.
  function automatic rule_t rule_lookup(input logic [StW-1:0] st, input event_e ev);
    rule_t r;
    r = '0;
    case (st)
      ST_NONE: begin
        case (ev)
          EV_SYN:     r = mk_rule(ST_SYN_SENT, MK_KEEP, TM_SYN_SENT, 1'b0, 1'b0);
          EV_SYNACK:  r = mk_rule(ST_SYN_RECV, MK_KEEP, TM_SYN_RECV, 1'b0, 1'b0);
          EV_ACK:     r = mk_rule(ST_MID_STREAM, MK_KEEP, TM_MID_STREAM, 1'b0, 1'b0);
          EV_FIN_IN:  r = mk_rule(ST_FIN_WAIT, MK_IN, TM_FIN_WAIT, 1'b0, 1'b0);
          EV_FIN_OUT: r = mk_rule(ST_CLOSE_WAIT, MK_OUT, TM_CLOSE_WAIT, 1'b0, 1'b0);
          EV_RST:     r = mk_rule(ST_CLOSE, MK_KEEP, TM_CLOSE, 1'b0, 1'b0);
          default:    r = '0;
        endcase
      end
      ST_SYN_SENT: begin
        case (ev)
          EV_SYN:     r = mk_rule(ST_SYN_SENT, MK_KEEP, TM_SYN_SENT, 1'b0, 1'b0);
          EV_SYNACK:  r = mk_rule(ST_SYN_RECV, MK_KEEP, TM_SYN_RECV, 1'b0, 1'b0);
          EV_RST:     r = mk_rule(ST_CLOSE, MK_KEEP, TM_CLOSE, 1'b0, 1'b0);
          default:    r = '0;
        endcase
      end
      ST_SYN_RECV: begin
        case (ev)
          EV_SYNACK:  r = mk_rule(ST_SYN_RECV, MK_KEEP, TM_SYN_RECV, 1'b0, 1'b0);
          EV_ACK:     r = mk_rule(ST_ESTABLISHED, MK_KEEP, TM_ESTABLISHED, 1'b0, 1'b0);
          EV_FIN_IN:  r = mk_rule(ST_FIN_WAIT, MK_IN, TM_FIN_WAIT, 1'b0, 1'b0);
          EV_FIN_OUT: r = mk_rule(ST_FIN_WAIT, MK_OUT, TM_FIN_WAIT, 1'b0, 1'b0);
          EV_RST:     r = mk_rule(ST_CLOSE, MK_KEEP, TM_CLOSE, 1'b0, 1'b0);
          default:    r = '0;
        endcase
      end
      ST_ESTABLISHED: begin
        case (ev)
          EV_SYN:     r = mk_rule(ST_SYN_SENT, MK_CLR, TM_SYN_SENT, 1'b0, 1'b0);
          EV_SYNACK:  r = mk_rule(ST_ESTABLISHED, MK_KEEP, TM_ESTABLISHED, 1'b0, 1'b0);
          EV_ACK:     r = mk_rule(ST_ESTABLISHED, MK_KEEP, TM_ESTABLISHED, 1'b1, 1'b0);
          EV_FIN_IN:  r = mk_rule(ST_FIN_WAIT, MK_IN, TM_FIN_WAIT, 1'b0, 1'b0);
          EV_FIN_OUT: r = mk_rule(ST_CLOSE_WAIT, MK_OUT, TM_CLOSE_WAIT, 1'b0, 1'b0);
          EV_RST:     r = mk_rule(ST_CLOSE, MK_KEEP, TM_CLOSE, 1'b0, 1'b0);
          default:    r = '0;
        endcase
      end
      ST_FIN_WAIT: begin
        case (ev)
          EV_ACK:     r = mk_rule(ST_FIN_WAIT, MK_KEEP, TM_FIN_WAIT, 1'b0, 1'b0);
          EV_FIN_IN:  r = mk_rule(ST_FIN_WAIT, MK_IN, TM_FIN_WAIT, 1'b0, 1'b0);
          EV_FIN_OUT: r = mk_rule(ST_TIME_WAIT, MK_OUT, TM_TIME_WAIT, 1'b0, 1'b0);
          EV_RST:     r = mk_rule(ST_CLOSE, MK_KEEP, TM_CLOSE, 1'b0, 1'b0);
          default:    r = '0;
        endcase
      end
      ST_CLOSE_WAIT: begin
        case (ev)
          EV_ACK:     r = mk_rule(ST_CLOSE_WAIT, MK_KEEP, TM_CLOSE_WAIT, 1'b0, 1'b0);
          EV_FIN_IN:  r = mk_rule(ST_CLOSING_ACK, MK_IN, TM_CLOSING_ACK, 1'b0, 1'b0);
          EV_RST:     r = mk_rule(ST_CLOSE, MK_KEEP, TM_CLOSE, 1'b0, 1'b0);
          default:    r = '0;
        endcase
      end
      ST_CLOSING_ACK: begin
        case (ev)
          EV_ACK:     r = mk_rule(ST_TIME_WAIT, MK_KEEP, TM_TIME_WAIT, 1'b0, 1'b0);
          EV_RST:     r = mk_rule(ST_CLOSE, MK_KEEP, TM_CLOSE, 1'b0, 1'b0);
          default:    r = '0;
        endcase
      end
      ST_TIME_WAIT: begin
        case (ev)
          EV_SYN:     r = mk_rule(ST_SYN_SENT, MK_CLR, TM_SYN_SENT, 1'b0, 1'b0);
          EV_ACK:     r = mk_rule(ST_TIME_WAIT, MK_KEEP, TM_TIME_WAIT, 1'b0, 1'b0);
          EV_RST:     r = mk_rule(ST_CLOSE, MK_KEEP, TM_CLOSE, 1'b0, 1'b0);
          default:    r = '0;
        endcase
      end
      ST_CLOSE: begin
        case (ev)
          EV_SYN:     r = mk_rule(ST_SYN_SENT, MK_CLR, TM_SYN_SENT, 1'b0, 1'b0);
          EV_RST:     r = mk_rule(ST_CLOSE, MK_KEEP, TM_CLOSE, 1'b0, 1'b0);
          default:    r = '0;
        endcase
      end
      ST_MID_STREAM: begin
        case (ev)
          EV_SYN:     r = mk_rule(ST_SYN_SENT, MK_CLR, TM_SYN_SENT, 1'b0, 1'b0);
          EV_SYNACK:  r = mk_rule(ST_MID_STREAM, MK_KEEP, TM_MID_STREAM, 1'b0, 1'b0);
          EV_ACK:     r = mk_rule(ST_MID_STREAM, MK_KEEP, TM_MID_STREAM, 1'b0, 1'b1);
          EV_FIN_IN:  r = mk_rule(ST_FIN_WAIT, MK_IN, TM_FIN_WAIT, 1'b0, 1'b0);
          EV_FIN_OUT: r = mk_rule(ST_CLOSE_WAIT, MK_OUT, TM_CLOSE_WAIT, 1'b0, 1'b0);
          EV_RST:     r = mk_rule(ST_CLOSE, MK_KEEP, TM_CLOSE, 1'b0, 1'b0);
          default:    r = '0;
        endcase
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### design/tcp_conntrack_fsm_table_core.sv
// ----------------------------------------------------------------------------
// TCP connection tracking core
// Per-flow TCP state tracking with expiry deadlines for source NAT.
// ----------------------------------------------------------------------------
// After reset the core clears its 4096-entry flow table, one entry per cycle,
// and holds busy_o high while it does so; configuration writes are taken
// throughout. An event is transferred when start_i is high and busy_o is low.
// Each event yields exactly one result, shown for one cycle with valid_o high;
// the receiver cannot stall it. A result passes through the queue, the flow
// table read and the result register, and each event waiting ahead of it in
// the queue delays it further. The back end takes a new event only once the
// read-modify-write of the previous one in the single flow table memory is
// done (entry read in one cycle, written in the next). A two-entry command
// queue lets start_i be taken while an earlier event is still being processed;
// busy_o rises when it is full. The configuration port is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_conntrack_fsm_table_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tcf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tcf_pkg::TickW-1:0]     cfg_data_i,
  // Packet events
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [tcf_pkg::IdxW-1:0]      flow_index_i,
  input  logic [tcf_pkg::FlagW-1:0]     tcp_flag_bits_i,
  input  logic                          from_outside_i,
  input  logic [tcf_pkg::TickW-1:0]     now_ticks_i,
  // Results
  output logic                          valid_o,
  output logic [tcf_pkg::StatusW-1:0]   status_o,
  output logic [tcf_pkg::IdxW-1:0]      flow_echo_o,
  output logic [tcf_pkg::StW-1:0]       new_state_o,
  output logic [tcf_pkg::MkW-1:0]       close_marks_o,
  output logic                          arm_expiry_o,
  output logic                          refresh_only_o,
  output logic [tcf_pkg::TickW-1:0]     deadline_ticks_o
);

  logic [tcf_pkg::NumTimers-1:0][tcf_pkg::TickW-1:0] timeout_q;
  logic               push, pop, clearing;
  tcf_pkg::cmd_t      front_cmd, queue_cmd;
  tcf_pkg::q_status_t q_status;
  tcf_pkg::result_t   res;

  // Timeout registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q[cfg_index_i] <= cfg_data_i;
    end
  end

  tcf_front u_front (
    .start_i         (start_i),
    .busy_o          (busy_o),
    .flow_index_i    (flow_index_i),
    .tcp_flag_bits_i (tcp_flag_bits_i),
    .from_outside_i  (from_outside_i),
    .now_ticks_i     (now_ticks_i),
    .q_status_i      (q_status),
    .clearing_i      (clearing),
    .push_o          (push),
    .cmd_o           (front_cmd)
  );

  tcf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (front_cmd),
    .pop_i    (pop),
    .cmd_o    (queue_cmd),
    .status_o (q_status)
  );

  tcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .cmd_i       (queue_cmd),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .timeout_i   (timeout_q),
    .res_valid_o (valid_o),
    .res_o       (res)
  );

  // Result fields.
  assign status_o         = res.status;
  assign flow_echo_o      = res.flow_echo;
  assign new_state_o      = res.new_state;
  assign close_marks_o    = res.close_marks;
  assign arm_expiry_o     = res.arm_expiry;
  assign refresh_only_o   = res.refresh_only;
  assign deadline_ticks_o = res.deadline_ticks;

endmodule

### design/tcf_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/tcf_front.sv
// ----------------------------------------------------------------------------
// TCP connection tracking front end
// Accepts packet events, decodes the TCP flags into an event, checks the
// flow index range and pushes the classified command into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcf_front (
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [tcf_pkg::IdxW-1:0]   flow_index_i,
  input  logic [tcf_pkg::FlagW-1:0]  tcp_flag_bits_i,
  input  logic                       from_outside_i,
  input  logic [tcf_pkg::TickW-1:0]  now_ticks_i,
  input  tcf_pkg::q_status_t         q_status_i,
  input  logic                       clearing_i,
  output logic                       push_o,
  output tcf_pkg::cmd_t              cmd_o
);

  // Hold off new events while the table is cleared or the queue is full.
  assign busy_o = clearing_i | q_status_i.full;
  assign push_o = start_i & ~busy_o;

  // Classify the event.
  always_comb begin
    cmd_o.flow_index   = flow_index_i;
    cmd_o.from_outside = from_outside_i;
    cmd_o.now_ticks    = now_ticks_i;
    cmd_o.event_code   = tcf_pkg::decode_event(tcp_flag_bits_i, from_outside_i);
    cmd_o.in_range     = (tcf_pkg::RangeW'(flow_index_i)
                          < tcf_pkg::RangeW'(tcf_pkg::FLOW_ENTRIES));
  end

endmodule

### design/tcf_queue.sv
// ----------------------------------------------------------------------------
// TCP connection tracking command queue
// Short FIFO of classified commands between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tcf_pkg::cmd_t      cmd_i,
  input  logic               pop_i,
  output tcf_pkg::cmd_t      cmd_o,
  output tcf_pkg::q_status_t status_o
);

  tcf_pkg::cmd_t                   slot_q [tcf_pkg::QueueDepth];
  logic [tcf_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [tcf_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [tcf_pkg::QCntW-1:0]       count_q, count_d;
  logic                            do_push, do_pop;

  localparam logic [tcf_pkg::QPtrW-1:0] LastPtr = tcf_pkg::QPtrW'(tcf_pkg::QueueDepth - 1);

  assign status_o.full  = (count_q == tcf_pkg::QCntW'(tcf_pkg::QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i & ~status_o.full;
  assign do_pop         = pop_i & ~status_o.empty;
  assign cmd_o          = slot_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Command storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### design/tcf_back.sv
// ----------------------------------------------------------------------------
// TCP connection tracking back end
// Clears the flow table after reset, then runs one read-modify-write of a
// flow entry per command: read the stored state and FIN marks, apply the
// transition table, write back when a rule applies and register the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcf_back (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  tcf_pkg::q_status_t                                q_status_i,
  input  tcf_pkg::cmd_t                                     cmd_i,
  output logic                                              pop_o,
  output logic                                              clearing_o,
  input  logic [tcf_pkg::NumTimers-1:0][tcf_pkg::TickW-1:0] timeout_i,
  output logic                                              res_valid_o,
  output tcf_pkg::result_t                                  res_o
);

  typedef enum logic [2:0] {
    BK_CLEAR = 3'b001,
    BK_IDLE  = 3'b010,
    BK_EXEC  = 3'b100
  } back_state_e;

  localparam logic [tcf_pkg::FlowAw-1:0] LastAddr = tcf_pkg::FlowAw'(tcf_pkg::FLOW_ENTRIES - 1);

  back_state_e                      state_q, state_d;
  logic [tcf_pkg::FlowAw-1:0]       clr_cnt_q, clr_cnt_d;
  tcf_pkg::cmd_t                    cur_q;
  logic                             res_valid_q;
  tcf_pkg::result_t                 res_q, res_d;

  logic                             ram_we;
  logic [tcf_pkg::FlowAw-1:0]       ram_waddr;
  logic [tcf_pkg::EntryW-1:0]       ram_wdata;
  logic [tcf_pkg::EntryW-1:0]       ram_rdata;

  logic [tcf_pkg::StW-1:0]          st_rd;
  logic [tcf_pkg::MkW-1:0]          mk_rd;
  tcf_pkg::rule_t                   rule;
  logic [tcf_pkg::StW-1:0]          new_st;
  logic [tcf_pkg::MkW-1:0]          new_mk;
  tcf_pkg::timer_sel_e              tm;
  logic                             refresh;
  logic                             apply;
  logic [tcf_pkg::TickW-1:0]        timer_val;

  assign clearing_o = (state_q == BK_CLEAR);
  assign pop_o      = (state_q == BK_IDLE) & ~q_status_i.empty;

  // Flow table: state in the upper bits, FIN marks in the lower bits.
  tcf_ram #(
    .Width (tcf_pkg::EntryW),
    .Depth (tcf_pkg::FLOW_ENTRIES)
  ) u_flow_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (pop_o),
    .raddr_i (tcf_pkg::FlowAw'(cmd_i.flow_index)),
    .rdata_o (ram_rdata)
  );

  assign st_rd = ram_rdata[tcf_pkg::EntryW-1:tcf_pkg::MkW];
  assign mk_rd = ram_rdata[tcf_pkg::MkW-1:0];
  assign rule  = tcf_pkg::rule_lookup(st_rd, cur_q.event_code);

  // Transition of the entry that was read in the previous cycle.
  always_comb begin
    new_st  = st_rd;
    new_mk  = mk_rd;
    tm      = rule.timer;
    refresh = rule.refresh;
    apply   = 1'b0;
    res_d   = '0;
    res_d.status    = tcf_pkg::STATUS_IGNORED;
    res_d.flow_echo = cur_q.flow_index;

    if (cur_q.in_range && (cur_q.event_code != tcf_pkg::EV_NONE)) begin
      if (st_rd > tcf_pkg::ST_MID_STREAM) begin
        res_d.status = tcf_pkg::STATUS_CORRUPT;
      end else if (rule.valid) begin
        apply  = 1'b1;
        new_st = rule.next;
        case (rule.mark)
          tcf_pkg::MK_KEEP: new_mk = mk_rd;
          tcf_pkg::MK_IN:   new_mk = mk_rd | 2'b01;
          tcf_pkg::MK_OUT:  new_mk = mk_rd | 2'b10;
          tcf_pkg::MK_CLR:  new_mk = '0;
          default:          new_mk = mk_rd;
        endcase
        // An ACK in mid-stream is promoted only when it comes from outside.
        if (rule.mid_ack) begin
          if (cur_q.from_outside) begin
            new_st  = tcf_pkg::ST_ESTABLISHED;
            tm      = tcf_pkg::TM_ESTABLISHED;
            refresh = 1'b0;
          end else begin
            refresh = 1'b1;
          end
        end
      end
    end

    // Timeout selection and deadline.
    if (tm == tcf_pkg::TM_CLOSING_ACK) begin
      timer_val = tcf_pkg::CLOSING_ACK_TICKS;
    end else begin
      timer_val = timeout_i[tcf_pkg::TmIdxW'(tm)];
    end

    if (cur_q.in_range) begin
      res_d.new_state   = new_st;
      res_d.close_marks = new_mk;
    end
    if (apply) begin
      res_d.status         = tcf_pkg::STATUS_APPLIED;
      res_d.arm_expiry     = 1'b1;
      res_d.refresh_only   = refresh;
      res_d.deadline_ticks = cur_q.now_ticks + timer_val;
    end
  end

  // Table write port: clearing pass or write-back.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tcf_pkg::FlowAw'(cur_q.flow_index);
    ram_wdata = {new_st, new_mk};
    if (state_q == BK_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (state_q == BK_EXEC) begin
      ram_we = apply;
    end
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      BK_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LastAddr) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (pop_o) begin
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        state_d = BK_IDLE;
      end
      default: begin
        state_d = BK_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_cnt_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      res_valid_q <= (state_q == BK_EXEC);
    end
  end

  // Command and result payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= cmd_i;
    end
    if (state_q == BK_EXEC) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### design/tcf_checker.sv
// ----------------------------------------------------------------------------
// TCP connection tracking port checker
// Checks result consistency and result spacing seen on the core's ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tcp_conntrack_fsm_table_core_macros.svh"

module tcf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [tcf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input logic [tcf_pkg::TickW-1:0]     cfg_data_i,
  input logic                          start_i,
  input logic                          busy_o,
  input logic [tcf_pkg::IdxW-1:0]      flow_index_i,
  input logic [tcf_pkg::FlagW-1:0]     tcp_flag_bits_i,
  input logic                          from_outside_i,
  input logic [tcf_pkg::TickW-1:0]     now_ticks_i,
  input logic                          valid_o,
  input logic [tcf_pkg::StatusW-1:0]   status_o,
  input logic [tcf_pkg::IdxW-1:0]      flow_echo_o,
  input logic [tcf_pkg::StW-1:0]       new_state_o,
  input logic [tcf_pkg::MkW-1:0]       close_marks_o,
  input logic                          arm_expiry_o,
  input logic                          refresh_only_o,
  input logic [tcf_pkg::TickW-1:0]     deadline_ticks_o
);

  // An applied transition always arms an expiry.
  `TCF_ASSERT_SAME(a_applied_arms, valid_o && (status_o == tcf_pkg::STATUS_APPLIED), arm_expiry_o, "applied transition without expiry")

  // Ignored and corrupt results carry no deadline.
  `TCF_ASSERT_SAME(a_not_applied_quiet, valid_o && (status_o != tcf_pkg::STATUS_APPLIED), !arm_expiry_o && !refresh_only_o && (deadline_ticks_o == '0), "deadline on a result that was not applied")

  // An applied transition lands in a defined connection state.
  `TCF_ASSERT_SAME(a_applied_state, valid_o && (status_o == tcf_pkg::STATUS_APPLIED), new_state_o <= tcf_pkg::ST_MID_STREAM, "applied transition to undefined state")

  // Each read-modify-write returns to idle after its write, so results never come back to back.
  `TCF_ASSERT_NEXT(a_result_spacing, valid_o, !valid_o, "results in consecutive cycles")

endmodule

bind tcp_conntrack_fsm_table_core tcf_checker u_tcf_checker (.*);
